// ===== src/utf8_to_utf16_stream_decoder_defines.svh =====
// ---------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder assertion macros
// Shared concurrent assertion forms for the decoder RTL.
// ---------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_STREAM_DECODER_DEFINES_SVH
`define UTF8_TO_UTF16_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define U8U16_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("decoder assertion failed");

// Next-cycle implication, disabled while in reset
`define U8U16_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("decoder assertion failed");

`endif

// ===== src/u8u16_pkg.sv =====
// ---------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder package
// Byte class limits, sequence state codes and shared result types.
// ---------------------------------------------------------------------------
package u8u16_pkg;

    localparam int COUNT_BITS = 16;
    localparam int UNIT_W     = 16;
    localparam int BYTE_W     = 8;

    localparam logic [BYTE_W-1:0] C_ASCII_LIMIT   = 8'h80;
    localparam logic [BYTE_W-1:0] C_LEAD2_MIN     = 8'hC2;
    localparam logic [BYTE_W-1:0] C_LEAD3_MIN     = 8'hE0;
    localparam logic [BYTE_W-1:0] C_LEAD4_MIN     = 8'hF0;
    localparam logic [BYTE_W-1:0] C_E0_SECOND_MIN = 8'hA0;
    localparam logic [BYTE_W-1:0] C_TERMINATOR    = 8'h00;
    localparam logic [1:0]        C_CONT_TAG      = 2'b10;

    // Continuation bytes still expected
    localparam logic [1:0] P_NONE = 2'd0;
    localparam logic [1:0] P_ONE  = 2'd1;
    localparam logic [1:0] P_TWO  = 2'd2;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    typedef struct packed {
        logic              has_result;
        logic [UNIT_W-1:0] code_unit;
        logic              bad_input;
        logic              string_end;
        logic [UNIT_W-1:0] unit_count;
    } t_result;

    typedef struct packed {
        logic error_seen;
        logic [1:0] bytes_pending;
    } t_status;

    // Reported count saturates at the 16-bit field maximum
    function automatic logic [UNIT_W-1:0] f_shown(input logic [COUNT_BITS-1:0] cnt);
        logic [31:0] wide;
        wide = 32'(cnt);
        return (wide > 32'h0000_FFFF) ? 16'hFFFF : wide[UNIT_W-1:0];
    endfunction

endpackage

// ===== src/utf8_to_utf16_stream_decoder.sv =====
// ---------------------------------------------------------------------------
// UTF-8 to UTF-16 stream decoder (BMP, up to three-byte sequences)
// A result is held in the result register after its last byte passes the input register.
// Throughput: 1 byte per cycle unless the output stalls; input register and result register decouple.
// Reset: synchronous active-low; clears handshake and per-string state.
// ---------------------------------------------------------------------------
`include "utf8_to_utf16_stream_decoder_defines.svh"

module utf8_to_utf16_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] code_unit, [31:16] unit_count
    output logic        m_axis_tuser,   // [0] bad_input
    output logic        m_axis_tlast    // string_end
);
    import u8u16_pkg::*;

    logic              in_valid;
    logic [BYTE_W-1:0] in_byte;
    logic              advance;
    t_result           step_res;
    t_status           core_stat;

    logic              r_out_valid;
    logic              n_out_valid;
    logic [UNIT_W-1:0] r_code_unit;
    logic [UNIT_W-1:0] r_unit_count;
    logic              r_bad;
    logic              r_end;

    // move the held byte through the decoder when the result slot is free
    assign advance = in_valid && (!r_out_valid || m_axis_tready);

    u8u16_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .i_byte    (s_axis_tdata),
        .o_ready   (s_axis_tready),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_byte    (in_byte)
    );

    u8u16_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (in_byte),
        .o_res     (step_res),
        .o_stat    (core_stat)
    );

    assign n_out_valid = advance ? step_res.has_result : (r_out_valid && !m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && step_res.has_result) begin
            r_code_unit  <= step_res.code_unit;
            r_unit_count <= step_res.unit_count;
            r_bad        <= step_res.bad_input;
            r_end        <= step_res.string_end;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_unit_count, r_code_unit};
    assign m_axis_tuser  = r_bad;
    assign m_axis_tlast  = r_end;

    `U8U16_ASSERT_NOW(a_bad_is_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 32'h0)
    `U8U16_ASSERT_NOW(a_end_unit_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tdata[15:0] == 16'h0)
    `U8U16_ASSERT_NOW(a_stall_blocks_in, i_clk, i_rst_n, in_valid && r_out_valid && !m_axis_tready, !s_axis_tready)
    `U8U16_ASSERT_NEXT(a_error_latched, i_clk, i_rst_n, advance && step_res.bad_input && !step_res.string_end, core_stat.error_seen && core_stat.bytes_pending == P_NONE)

endmodule

// ===== src/u8u16_in_stage.sv =====
// ---------------------------------------------------------------------------
// UTF-8 decoder input stage
// Registers one incoming byte; refills in the same cycle it drains.
// ---------------------------------------------------------------------------
module u8u16_in_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [u8u16_pkg::BYTE_W-1:0]  i_byte,
    output logic                          o_ready,
    input  logic                          i_advance,
    output logic                          o_valid,
    output logic [u8u16_pkg::BYTE_W-1:0]  o_byte
);
    import u8u16_pkg::*;

    logic              r_valid;
    logic              n_valid;
    logic [BYTE_W-1:0] r_byte;

    assign o_ready = !r_valid || i_advance;
    assign n_valid = (i_valid && o_ready) || (r_valid && !i_advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// ===== src/u8u16_core.sv =====
// ---------------------------------------------------------------------------
// UTF-8 decoder sequence core
// Holds the per-string sequence state and decodes one byte per advance.
// ---------------------------------------------------------------------------
module u8u16_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_advance,
    input  logic [u8u16_pkg::BYTE_W-1:0]  i_byte,
    output u8u16_pkg::t_result            o_res,
    output u8u16_pkg::t_status            o_stat
);
    import u8u16_pkg::*;

    logic [1:0]            r_pending;
    logic [1:0]            n_pending;
    logic [UNIT_W-1:0]     r_partial;
    logic [UNIT_W-1:0]     n_partial;
    logic                  r_e0;
    logic                  n_e0;
    logic                  r_err;
    logic                  n_err;
    logic [COUNT_BITS-1:0] r_count;
    logic [COUNT_BITS-1:0] n_count;
    logic [COUNT_BITS-1:0] count_inc;
    logic                  is_cont;
    t_result               res;

    assign count_inc = (r_count == CNT_MAX) ? r_count : r_count + 1'b1;
    assign is_cont   = (i_byte[7:6] == C_CONT_TAG);

    always_comb begin
        n_pending = r_pending;
        n_partial = r_partial;
        n_e0      = r_e0;
        n_err     = r_err;
        n_count   = r_count;
        res       = '0;
        if (i_byte == C_TERMINATOR) begin
            // close the string and return to the reset state
            res.has_result = 1'b1;
            res.string_end = 1'b1;
            res.bad_input  = r_err || (r_pending != P_NONE);
            res.unit_count = res.bad_input ? '0 : f_shown(r_count);
            n_pending = P_NONE;
            n_partial = '0;
            n_e0      = 1'b0;
            n_err     = 1'b0;
            n_count   = '0;
        end else if (!r_err) begin
            if (r_pending == P_NONE) begin
                priority if (i_byte < C_ASCII_LIMIT) begin
                    res.has_result = 1'b1;
                    res.code_unit  = {8'h00, i_byte};
                    res.unit_count = f_shown(count_inc);
                    n_count        = count_inc;
                end else if (i_byte < C_LEAD2_MIN) begin
                    res.has_result = 1'b1;
                    res.bad_input  = 1'b1;
                    n_err          = 1'b1;
                end else if (i_byte < C_LEAD3_MIN) begin
                    n_partial = {5'b0, i_byte[4:0], 6'b0};
                    n_pending = P_ONE;
                    n_e0      = 1'b0;
                end else if (i_byte < C_LEAD4_MIN) begin
                    n_partial = {i_byte[3:0], 12'b0};
                    n_pending = P_TWO;
                    n_e0      = (i_byte == C_LEAD3_MIN);
                end else begin
                    res.has_result = 1'b1;
                    res.bad_input  = 1'b1;
                    n_err          = 1'b1;
                end
            end else if (!is_cont || (r_pending == P_TWO && r_e0
                                      && i_byte < C_E0_SECOND_MIN)) begin
                // bad continuation or overlong three-byte form: drop the sequence
                res.has_result = 1'b1;
                res.bad_input  = 1'b1;
                n_err          = 1'b1;
                n_pending      = P_NONE;
                n_partial      = '0;
                n_e0           = 1'b0;
            end else if (r_pending == P_TWO) begin
                n_partial = r_partial | {4'b0, i_byte[5:0], 6'b0};
                n_pending = P_ONE;
                n_e0      = 1'b0;
            end else begin
                res.has_result = 1'b1;
                res.code_unit  = r_partial | {10'b0, i_byte[5:0]};
                res.unit_count = f_shown(count_inc);
                n_count        = count_inc;
                n_pending      = P_NONE;
                n_partial      = '0;
                n_e0           = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= P_NONE;
            r_partial <= '0;
            r_e0      <= 1'b0;
            r_err     <= 1'b0;
            r_count   <= '0;
        end else if (i_advance) begin
            r_pending <= n_pending;
            r_partial <= n_partial;
            r_e0      <= n_e0;
            r_err     <= n_err;
            r_count   <= n_count;
        end
    end

    assign o_res                = res;
    assign o_stat.error_seen    = r_err;
    assign o_stat.bytes_pending = r_pending;

endmodule
